// File: rtl/stb_pkg.sv
`default_nettype none

package stb_pkg;

    // number of timer slots and the width of a slot index
    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LAST_SLOT = SLOTS - 1;

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 4;
    localparam int MS_W   = 15;
    localparam int TIME_W = 16;
    localparam int KIND_W = 2;
    localparam int MPT_W  = 8;

    // reset value of the per-tick step
    localparam logic [MPT_W-1:0] MPT_RESET = 8'd1;

    // command opcodes
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_FREE    = 3'd2,
        OP_SET     = 3'd3,
        OP_STOP    = 3'd4,
        OP_RESTART = 3'd5
    } t_opcode;

    // result kinds
    localparam logic [KIND_W-1:0] EV_ANSWER  = 2'd0;
    localparam logic [KIND_W-1:0] EV_EXPIRED = 2'd1;
    localparam logic [KIND_W-1:0] EV_CLOSE   = 2'd2;

    // datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_FREE,
        DP_SET,
        DP_STOP,
        DP_BAD,
        DP_RST_RD,
        DP_RST_WR,
        DP_ALLOC_START,
        DP_ALLOC_STEP,
        DP_TICK_START,
        DP_TICK_STEP,
        DP_TICK_CLOSE
    } t_dp_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic idx_last;
        logic cur_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/stb_datapath.sv
`default_nettype none

module stb_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stb_pkg::t_dp_op             i_op,
    input  wire logic [stb_pkg::ID_W-1:0]    i_timer_id,
    input  wire logic [stb_pkg::MS_W-1:0]    i_ms_value,
    input  wire logic                        i_cfg_we,
    input  wire logic [stb_pkg::MPT_W-1:0]   i_cfg_data,
    output stb_pkg::t_dp_status              o_status,
    output logic                             o_strobe,
    output logic [stb_pkg::KIND_W-1:0]       o_event_kind,
    output logic                             o_ok,
    output logic [stb_pkg::ID_W-1:0]         o_slot,
    output logic                             o_last
);

    // slot flags, cleared at reset
    logic [stb_pkg::SLOTS-1:0] r_alloc;
    logic [stb_pkg::SLOTS-1:0] r_run;

    // per-slot time left and timeout, written before any use
    logic [stb_pkg::TIME_W-1:0] r_time_mem   [stb_pkg::SLOTS];
    logic [stb_pkg::MS_W-1:0]   r_reload_mem [stb_pkg::SLOTS];
    logic [stb_pkg::TIME_W-1:0] r_time_rd;
    logic [stb_pkg::MS_W-1:0]   r_reload_rd;

    logic [stb_pkg::IDX_W-1:0]  r_idx;
    logic [stb_pkg::ID_W-1:0]   r_id;
    logic [stb_pkg::MS_W-1:0]   r_ms;
    logic                       r_valid;
    logic [stb_pkg::MPT_W-1:0]  r_mpt;

    logic                       id_in_range;
    logic [stb_pkg::IDX_W-1:0]  id_idx;
    logic                       id_ok;
    logic [stb_pkg::IDX_W-1:0]  held_idx;
    logic                       idx_last;
    logic                       cur_live;
    logic [stb_pkg::TIME_W:0]   n_diff;

    logic                       n_rd_en;
    logic [stb_pkg::IDX_W-1:0]  n_rd_addr;
    logic                       n_wr_time;
    logic                       n_wr_reload;
    logic [stb_pkg::IDX_W-1:0]  n_wr_addr;
    logic [stb_pkg::TIME_W-1:0] n_time;
    logic [stb_pkg::MS_W-1:0]   n_reload;

    // addressed slot decode
    assign id_in_range = 32'(i_timer_id) < stb_pkg::SLOTS;
    assign id_idx      = stb_pkg::IDX_W'(i_timer_id);
    assign id_ok       = id_in_range && r_alloc[id_idx];
    assign held_idx    = stb_pkg::IDX_W'(r_id);

    // sweep position
    assign idx_last = (32'(r_idx) == stb_pkg::LAST_SLOT);
    assign cur_live = r_alloc[r_idx] && r_run[r_idx];
    assign n_diff   = {r_time_rd[stb_pkg::TIME_W-1], r_time_rd}
                    - {{(stb_pkg::TIME_W + 1 - stb_pkg::MPT_W){1'b0}}, r_mpt};

    assign o_status.idx_last = idx_last;
    assign o_status.cur_free = !r_alloc[r_idx];

    // memory port selection
    always_comb begin
        n_rd_en     = 1'b0;
        n_rd_addr   = id_idx;
        n_wr_time   = 1'b0;
        n_wr_reload = 1'b0;
        n_wr_addr   = r_idx;
        n_time      = '0;
        n_reload    = r_ms;
        unique case (i_op)
            stb_pkg::DP_SET: begin
                n_wr_time   = id_ok;
                n_wr_reload = id_ok;
                n_wr_addr   = id_idx;
                n_time      = {1'b0, i_ms_value};
                n_reload    = i_ms_value;
            end
            stb_pkg::DP_RST_RD: begin
                n_rd_en   = id_in_range;
                n_rd_addr = id_idx;
            end
            stb_pkg::DP_RST_WR: begin
                n_wr_time = r_valid;
                n_wr_addr = held_idx;
                n_time    = {1'b0, r_reload_rd};
            end
            stb_pkg::DP_ALLOC_STEP: begin
                n_wr_time   = !r_alloc[r_idx];
                n_wr_reload = !r_alloc[r_idx];
            end
            stb_pkg::DP_TICK_START: begin
                n_rd_en   = 1'b1;
                n_rd_addr = '0;
            end
            stb_pkg::DP_TICK_STEP: begin
                n_rd_en   = !idx_last;
                n_rd_addr = r_idx + 1'b1;
                n_wr_time = cur_live;
                n_time    = n_diff[stb_pkg::TIME_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (n_wr_time) begin
            r_time_mem[n_wr_addr] <= n_time;
        end
        if (n_wr_reload) begin
            r_reload_mem[n_wr_addr] <= n_reload;
        end
        if (n_rd_en) begin
            r_time_rd   <= r_time_mem[n_rd_addr];
            r_reload_rd <= r_reload_mem[n_rd_addr];
        end
    end

    // latched command fields and sweep index
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            stb_pkg::DP_RST_RD: begin
                r_id    <= i_timer_id;
                r_valid <= id_ok;
            end
            stb_pkg::DP_ALLOC_START, stb_pkg::DP_TICK_START: begin
                r_idx <= '0;
                r_ms  <= i_ms_value;
            end
            stb_pkg::DP_ALLOC_STEP, stb_pkg::DP_TICK_STEP: begin
                r_idx <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // slot flags and per-tick step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_run   <= '0;
            r_mpt   <= stb_pkg::MPT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mpt <= i_cfg_data;
            end
            unique case (i_op)
                stb_pkg::DP_FREE: begin
                    if (id_ok) begin
                        r_alloc[id_idx] <= 1'b0;
                        r_run[id_idx]   <= 1'b0;
                    end
                end
                stb_pkg::DP_SET: begin
                    if (id_ok) begin
                        r_run[id_idx] <= 1'b1;
                    end
                end
                stb_pkg::DP_STOP: begin
                    if (id_ok) begin
                        r_run[id_idx] <= 1'b0;
                    end
                end
                stb_pkg::DP_RST_WR: begin
                    if (r_valid) begin
                        r_run[held_idx] <= 1'b1;
                    end
                end
                stb_pkg::DP_ALLOC_STEP: begin
                    if (!r_alloc[r_idx]) begin
                        r_alloc[r_idx] <= 1'b1;
                        r_run[r_idx]   <= 1'b0;
                    end
                end
                stb_pkg::DP_TICK_STEP: begin
                    if (cur_live && n_diff[stb_pkg::TIME_W]) begin
                        r_run[r_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            unique case (i_op)
                stb_pkg::DP_FREE, stb_pkg::DP_SET, stb_pkg::DP_STOP, stb_pkg::DP_BAD,
                stb_pkg::DP_RST_WR, stb_pkg::DP_TICK_CLOSE: begin
                    o_strobe <= 1'b1;
                end
                stb_pkg::DP_ALLOC_STEP: begin
                    o_strobe <= !r_alloc[r_idx] || idx_last;
                end
                stb_pkg::DP_TICK_STEP: begin
                    o_strobe <= cur_live && n_diff[stb_pkg::TIME_W];
                end
                default: begin
                    o_strobe <= 1'b0;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            stb_pkg::DP_FREE, stb_pkg::DP_SET, stb_pkg::DP_STOP, stb_pkg::DP_RST_RD: begin
                o_event_kind <= stb_pkg::EV_ANSWER;
                o_ok         <= id_ok;
                o_slot       <= i_timer_id;
                o_last       <= 1'b1;
            end
            stb_pkg::DP_BAD: begin
                o_event_kind <= stb_pkg::EV_ANSWER;
                o_ok         <= 1'b0;
                o_slot       <= i_timer_id;
                o_last       <= 1'b1;
            end
            stb_pkg::DP_ALLOC_STEP: begin
                o_event_kind <= stb_pkg::EV_ANSWER;
                o_ok         <= !r_alloc[r_idx];
                o_slot       <= r_alloc[r_idx] ? '0 : stb_pkg::ID_W'(r_idx);
                o_last       <= 1'b1;
            end
            stb_pkg::DP_TICK_STEP: begin
                o_event_kind <= stb_pkg::EV_EXPIRED;
                o_ok         <= 1'b1;
                o_slot       <= stb_pkg::ID_W'(r_idx);
                o_last       <= 1'b0;
            end
            stb_pkg::DP_TICK_CLOSE: begin
                o_event_kind <= stb_pkg::EV_CLOSE;
                o_ok         <= 1'b1;
                o_slot       <= '0;
                o_last       <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/stb_ctrl.sv
`default_nettype none

module stb_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [stb_pkg::OP_W-1:0]  i_opcode,
    input  wire stb_pkg::t_dp_status       i_status,
    output stb_pkg::t_dp_op                o_op,
    output logic                           o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_RESTART,
        S_TICK,
        S_TICK_END
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    // command decode and sequencing
    always_comb begin
        n_state = r_state;
        o_op    = stb_pkg::DP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (stb_pkg::t_opcode'(i_opcode))
                        stb_pkg::OP_TICK: begin
                            o_op    = stb_pkg::DP_TICK_START;
                            n_state = S_TICK;
                        end
                        stb_pkg::OP_ALLOC: begin
                            o_op    = stb_pkg::DP_ALLOC_START;
                            n_state = S_ALLOC;
                        end
                        stb_pkg::OP_FREE: o_op = stb_pkg::DP_FREE;
                        stb_pkg::OP_SET:  o_op = stb_pkg::DP_SET;
                        stb_pkg::OP_STOP: o_op = stb_pkg::DP_STOP;
                        stb_pkg::OP_RESTART: begin
                            o_op    = stb_pkg::DP_RST_RD;
                            n_state = S_RESTART;
                        end
                        default: o_op = stb_pkg::DP_BAD;
                    endcase
                end
            end
            S_ALLOC: begin
                o_op = stb_pkg::DP_ALLOC_STEP;
                if (i_status.cur_free || i_status.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESTART: begin
                o_op    = stb_pkg::DP_RST_WR;
                n_state = S_IDLE;
            end
            S_TICK: begin
                o_op = stb_pkg::DP_TICK_STEP;
                if (i_status.idx_last) begin
                    n_state = S_TICK_END;
                end
            end
            S_TICK_END: begin
                o_op    = stb_pkg::DP_TICK_CLOSE;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/software_timer_bank.sv
// software_timer_bank: bank of one-shot countdown timers, one command per item.
// free, set, stop and bad opcodes: answer in the cycle after the accept, next item the cycle after.
// restart: one read of the timeout memory, then one write.
// alloc: one cycle per slot visited by the in-order search, plus a start step.
// tick: one cycle per slot through the time-left memory, results leave as they form.
// reset: all slots free and stopped, ms_per_tick back to 1; no clearing pass.
`default_nettype none

module software_timer_bank (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [stb_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [stb_pkg::ID_W-1:0]    i_timer_id,
    input  wire logic [stb_pkg::MS_W-1:0]    i_ms_value,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [stb_pkg::MPT_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output logic [stb_pkg::KIND_W-1:0]       o_event_kind,
    output logic                             o_ok,
    output logic [stb_pkg::ID_W-1:0]         o_slot,
    output logic                             o_last
);

    stb_pkg::t_dp_op     dp_op;
    stb_pkg::t_dp_status dp_status;
    logic                cfg_we;

    // register writes only between items
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer
    stb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (dp_status),
        .o_op     (dp_op),
        .o_busy   (busy)
    );

    // slot storage and result registers
    stb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (dp_op),
        .i_timer_id   (i_timer_id),
        .i_ms_value   (i_ms_value),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_status     (dp_status),
        .o_strobe     (o_strobe),
        .o_event_kind (o_event_kind),
        .o_ok         (o_ok),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // opcodes the block does not define
    localparam logic [stb_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [stb_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
    // cycles to let the block settle before a register write and at the end
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 4000;

    // one result of the block
    typedef struct packed {
        logic [stb_pkg::KIND_W-1:0] kind;
        logic                       ok;
        logic [stb_pkg::ID_W-1:0]   slot;
        logic                       last;
    } t_timer_event;

    // timer bank prediction and result checking
    class t_timer_scoreboard;
        bit                         slot_alloc[stb_pkg::SLOTS];
        bit                         slot_run[stb_pkg::SLOTS];
        logic [stb_pkg::TIME_W-1:0] slot_left[stb_pkg::SLOTS];
        logic [stb_pkg::MS_W-1:0]   slot_timeout[stb_pkg::SLOTS];
        logic [stb_pkg::MPT_W-1:0]  tick_step;
        t_timer_event               awaited[$];
        int                         errors;
        int                         reports;

        function new();
            int i;
            for (i = 0; i < stb_pkg::SLOTS; i++) begin
                slot_alloc[i]   = 0;
                slot_run[i]     = 0;
                slot_left[i]    = '0;
                slot_timeout[i] = '0;
            end
            tick_step = stb_pkg::MPT_RESET;
            errors    = 0;
            reports   = 0;
        endfunction

        function void set_step(logic [stb_pkg::MPT_W-1:0] value);
            tick_step = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // a random allocated slot, or any slot when none is allocated
        function logic [stb_pkg::ID_W-1:0] pick_slot();
            int live[$];
            int i;
            for (i = 0; i < stb_pkg::SLOTS; i++)
                if (slot_alloc[i])
                    live.push_back(i);
            if (live.size() == 0)
                return stb_pkg::ID_W'($urandom_range(0, stb_pkg::SLOTS - 1));
            return stb_pkg::ID_W'(live[$urandom_range(0, live.size() - 1)]);
        endfunction

        function void push_event(logic [stb_pkg::KIND_W-1:0] kind, logic ok,
                                 logic [stb_pkg::ID_W-1:0] slot, logic last);
            t_timer_event ev;
            ev.kind = kind;
            ev.ok   = ok;
            ev.slot = slot;
            ev.last = last;
            awaited.push_back(ev);
        endfunction

        // work out the results of one accepted command
        function void note_command(logic [stb_pkg::OP_W-1:0] op,
                                   logic [stb_pkg::ID_W-1:0] id,
                                   logic [stb_pkg::MS_W-1:0] ms);
            int  i;
            int  t;
            bit  ok;
            bit  found;
            if (op == stb_pkg::OP_TICK) begin
                // count down every running timer, expiries in slot order
                for (i = 0; i < stb_pkg::SLOTS; i++) begin
                    if (slot_alloc[i] && slot_run[i]) begin
                        t = int'($signed(slot_left[i])) - int'(tick_step);
                        slot_left[i] = t[stb_pkg::TIME_W-1:0];
                        if (t < 0) begin
                            slot_run[i] = 0;
                            push_event(stb_pkg::EV_EXPIRED, 1'b1, stb_pkg::ID_W'(i), 1'b0);
                        end
                    end
                end
                push_event(stb_pkg::EV_CLOSE, 1'b1, '0, 1'b1);
            end else if (op == stb_pkg::OP_ALLOC) begin
                // lowest free slot, left stopped
                found = 0;
                for (i = 0; i < stb_pkg::SLOTS && !found; i++) begin
                    if (!slot_alloc[i]) begin
                        found           = 1;
                        slot_alloc[i]   = 1;
                        slot_run[i]     = 0;
                        slot_left[i]    = '0;
                        slot_timeout[i] = ms;
                        push_event(stb_pkg::EV_ANSWER, 1'b1, stb_pkg::ID_W'(i), 1'b1);
                    end
                end
                if (!found)
                    push_event(stb_pkg::EV_ANSWER, 1'b0, '0, 1'b1);
            end else begin
                // commands on one slot, refused on a free slot; spare opcodes are always refused
                ok = slot_alloc[id];
                case (op)
                    stb_pkg::OP_FREE: begin
                        if (ok) begin
                            slot_alloc[id] = 0;
                            slot_run[id]   = 0;
                        end
                    end
                    stb_pkg::OP_SET: begin
                        if (ok) begin
                            slot_left[id]    = stb_pkg::TIME_W'(ms);
                            slot_timeout[id] = ms;
                            slot_run[id]     = 1;
                        end
                    end
                    stb_pkg::OP_STOP: begin
                        if (ok)
                            slot_run[id] = 0;
                    end
                    stb_pkg::OP_RESTART: begin
                        if (ok) begin
                            slot_left[id] = stb_pkg::TIME_W'(slot_timeout[id]);
                            slot_run[id]  = 1;
                        end
                    end
                    default: ok = 0;
                endcase
                push_event(stb_pkg::EV_ANSWER, ok, id, 1'b1);
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                if (reports < 100)
                    $display("%0t mismatch on %s: expected %0d, actual %0d",
                             $time, name, want, got);
                reports++;
            end
        endfunction

        // compare one result with the oldest expectation
        function void check_result(logic [stb_pkg::KIND_W-1:0] kind, logic ok,
                                   logic [stb_pkg::ID_W-1:0] slot, logic last);
            t_timer_event ev;
            if (awaited.size() == 0) begin
                errors++;
                if (reports < 100)
                    $display("%0t unexpected result: expected none, actual kind %0d slot %0d",
                             $time, kind, slot);
                reports++;
                return;
            end
            ev = awaited.pop_front();
            compare_field("event_kind", ev.kind, kind);
            compare_field("ok", ev.ok, ok);
            compare_field("slot", ev.slot, slot);
            compare_field("last", ev.last, last);
        endfunction

        function void flag_leftover();
            if (awaited.size() != 0) begin
                errors++;
                $display("%0t results missing: expected %0d more, actual 0",
                         $time, awaited.size());
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [stb_pkg::OP_W-1:0]   i_opcode;
    logic [stb_pkg::ID_W-1:0]   i_timer_id;
    logic [stb_pkg::MS_W-1:0]   i_ms_value;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [stb_pkg::MPT_W-1:0]  i_cfg_data;
    logic                       o_strobe;
    logic [stb_pkg::KIND_W-1:0] o_event_kind;
    logic                       o_ok;
    logic [stb_pkg::ID_W-1:0]   o_slot;
    logic                       o_last;

    t_timer_scoreboard sb;
    int                idle_pct;

    software_timer_bank u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_timer_id   (i_timer_id),
        .i_ms_value   (i_ms_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_event_kind (o_event_kind),
        .o_ok         (o_ok),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_event_kind, o_ok, o_slot, o_last);
    end

    // hard stop on a hung run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // timeout mostly within reach of a few ticks, now and then the extremes
    function automatic logic [stb_pkg::MS_W-1:0] draw_timeout();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return stb_pkg::MS_W'($urandom_range(0, 32767));
            default: return stb_pkg::MS_W'($urandom_range(0, 4 * int'(sb.tick_step) + 3));
        endcase
    endfunction

    // idle cycles before an item, each cycle idle with the set chance
    task automatic maybe_pause();
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // present one command and hold it until accepted
    task automatic send(logic [stb_pkg::OP_W-1:0] op, logic [stb_pkg::ID_W-1:0] id,
                        logic [stb_pkg::MS_W-1:0] ms);
        maybe_pause();
        @(negedge i_clk);
        start      = 1'b1;
        i_opcode   = op;
        i_timer_id = id;
        i_ms_value = ms;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, id, ms);
    endtask

    // wait until the block has answered everything and gone quiet
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the per-tick step
    task automatic write_step(logic [stb_pkg::MPT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_step(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = stb_pkg::MPT_W'($urandom_range(0, 255));
    endtask

    // fill the bank past full, arm every slot to expire on one tick, then tick
    task automatic fill_and_arm();
        int i;
        logic [stb_pkg::MS_W-1:0] arm;
        repeat (stb_pkg::SLOTS + 1)
            send(stb_pkg::OP_ALLOC, stb_pkg::ID_W'($urandom_range(0, 15)), draw_timeout());
        for (i = 0; i < stb_pkg::SLOTS; i++) begin
            arm = (sb.tick_step == 0) ? '0
                : stb_pkg::MS_W'($urandom_range(0, int'(sb.tick_step) - 1));
            send(stb_pkg::OP_SET, stb_pkg::ID_W'(i), arm);
        end
        send(stb_pkg::OP_TICK, stb_pkg::ID_W'($urandom_range(0, 15)),
             stb_pkg::MS_W'($urandom_range(0, 32767)));
    endtask

    // one random command, mostly on live slots
    task automatic random_command();
        int r;
        logic [stb_pkg::OP_W-1:0] op;
        logic [stb_pkg::ID_W-1:0] id;
        r = $urandom_range(0, 99);
        if (r < 34)
            op = stb_pkg::OP_TICK;
        else if (r < 46)
            op = stb_pkg::OP_ALLOC;
        else if (r < 54)
            op = stb_pkg::OP_FREE;
        else if (r < 74)
            op = stb_pkg::OP_SET;
        else if (r < 81)
            op = stb_pkg::OP_STOP;
        else if (r < 95)
            op = stb_pkg::OP_RESTART;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        if ($urandom_range(0, 3) != 0)
            id = sb.pick_slot();
        else
            id = stb_pkg::ID_W'($urandom_range(0, 15));
        send(op, id, draw_timeout());
    endtask

    initial begin
        int waited;
        sb          = new();
        idle_pct    = 22;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = stb_pkg::OP_TICK;
        i_timer_id  = '0;
        i_ms_value  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: refusals on free slots, expiry from zero, reload, spare opcodes
        send(stb_pkg::OP_TICK, 4'd0, 15'd0);
        send(stb_pkg::OP_ALLOC, 4'd7, 15'd0);
        send(stb_pkg::OP_ALLOC, 4'd0, 15'h7fff);
        send(stb_pkg::OP_SET, 4'd2, 15'd5);
        send(stb_pkg::OP_STOP, 4'd2, 15'd0);
        send(stb_pkg::OP_RESTART, 4'd3, 15'd0);
        send(stb_pkg::OP_FREE, 4'd4, 15'd0);
        send(stb_pkg::OP_SET, 4'd0, 15'd0);
        send(stb_pkg::OP_TICK, 4'd15, 15'h7fff);
        send(stb_pkg::OP_RESTART, 4'd1, 15'd0);
        send(stb_pkg::OP_TICK, 4'd0, 15'd0);
        send(stb_pkg::OP_STOP, 4'd1, 15'd0);
        send(stb_pkg::OP_RESTART, 4'd0, 15'd0);
        send(stb_pkg::OP_SET, 4'd1, 15'd1);
        send(stb_pkg::OP_TICK, 4'd0, 15'd0);
        send(stb_pkg::OP_TICK, 4'd0, 15'd0);
        send(stb_pkg::OP_FREE, 4'd1, 15'd0);
        send(stb_pkg::OP_FREE, 4'd1, 15'd0);
        send(OP_SPARE_A, 4'd15, 15'd0);
        send(OP_SPARE_B, 4'd9, 15'h7fff);
        send(stb_pkg::OP_ALLOC, 4'd0, 15'h4000);
        send(stb_pkg::OP_SET, 4'd15, 15'h7fff);

        // largest step, sender idling now and then
        settle();
        write_step(8'd255);
        fill_and_arm();
        repeat (50) random_command();

        // random step, sender idling often
        settle();
        idle_pct = 47;
        write_step(stb_pkg::MPT_W'($urandom_range(2, 254)));
        fill_and_arm();
        repeat (50) random_command();

        // no idling: a zero step, then the smallest nonzero step
        settle();
        idle_pct = 0;
        write_step(8'd0);
        repeat (20) random_command();
        settle();
        write_step(8'd1);
        fill_and_arm();
        repeat (30) random_command();

        // drain
        @(negedge i_clk);
        start  = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: software_timer_bank.f
rtl/stb_pkg.sv
rtl/stb_datapath.sv
rtl/stb_ctrl.sv
rtl/software_timer_bank.sv
tb/testbench.sv
